### sv/tsh_pkg.sv
// Shared constants, types and arithmetic helpers for the thermistor converter.
`default_nettype none

package tsh_pkg;

  localparam int LOG_STAGES = 33;   // mantissa set-up plus one stage per fraction bit
  localparam int MUL_STAGES = 3;    // magnitude, partial products, sum
  localparam int DIV_STAGES = 16;   // one quotient bit per stage

  localparam logic [2:0] CFG_COEF_A  = 3'd0;
  localparam logic [2:0] CFG_COEF_B  = 3'd1;
  localparam logic [2:0] CFG_COEF_C  = 3'd2;
  localparam logic [2:0] CFG_DIVIDER = 3'd3;
  localparam logic [2:0] CFG_REF     = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_VHIGH = 2'd1;
  localparam logic [1:0] ST_VZERO = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [63:0] LN2_Q62      = 64'h2C5C_85FD_F473_DE6B;
  localparam logic [63:0] KELVIN_SCALE = 64'd7205759403792793600;  // 100 * 2^56
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] S65_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] S65_MIN = -65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [16:0] KELVIN_CENTI = 17'sd27315;
  localparam logic signed [16:0] TEMP_MAX     = 17'sd30000;

  typedef struct packed {
    logic [1:0] st;
    logic       sat;
  } flag_t;

  function automatic logic [4:0] msb_idx(input logic [19:0] x);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < 20; i++) begin
      if (x[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  // shift the product magnitude, clamp to the signed range and apply the sign
  function automatic logic signed [63:0] mul_fin(input logic [127:0] p, input logic neg,
                                                 input int unsigned s);
    logic [127:0] sh;
    logic [62:0]  mag;
    sh  = p >> s;
    mag = (|sh[127:63]) ? '1 : sh[62:0];
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > S65_MAX) return S64_MAX;
    else if (s < S65_MIN) return -S64_MAX;
    else return s[63:0];
  endfunction

endpackage

`default_nettype wire

### sv/tsh_log2.sv
// Pipelined log2 of a 20-bit integer, Q32 result, one fraction bit per stage.
`default_nettype none

module tsh_log2 (
  input  logic        clk,
  input  logic        en,
  input  logic [19:0] x,
  output logic [36:0] y   // integer part in [36:32], fraction below
);
  import tsh_pkg::*;

  logic [4:0]  k_r [LOG_STAGES];
  logic [31:0] m_r [LOG_STAGES];
  logic [31:0] f_r [LOG_STAGES];

  logic [4:0]  k0;
  logic [31:0] m0;

  assign k0 = msb_idx(x);
  assign m0 = {12'd0, x} << (5'd31 - k0);

  always_ff @(posedge clk) begin
    if (en) begin
      k_r[0] <= k0;
      m_r[0] <= m0;
      f_r[0] <= '0;
    end
  end

  genvar j;
  generate
    for (j = 1; j < LOG_STAGES; j++) begin : g_step
      logic [63:0] sq;
      logic [32:0] t;
      assign sq = m_r[j-1] * m_r[j-1];
      assign t  = sq[63:31];
      // mantissa squared reaching 2.0 yields a one bit and is halved
      always_ff @(posedge clk) begin
        if (en) begin
          k_r[j] <= k_r[j-1];
          m_r[j] <= t[32] ? t[32:1] : t[31:0];
          f_r[j] <= {f_r[j-1][30:0], t[32]};
        end
      end
    end
  endgenerate

  assign y = {k_r[LOG_STAGES-1], f_r[LOG_STAGES-1]};

endmodule

`default_nettype wire

### sv/tsh_mul.sv
// Three-stage signed 64x64 multiplier giving the full product magnitude and sign.
`default_nettype none

module tsh_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic [127:0]       p,
  output logic               neg
);
  import tsh_pkg::*;

  logic [63:0]  ua_r, ub_r;
  logic         neg0_r, neg1_r, neg2_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      neg0_r <= a[63] ^ b[63];
      ua_r   <= a[63] ? 64'(-a) : 64'(a);
      ub_r   <= b[63] ? 64'(-b) : 64'(b);

      neg1_r <= neg0_r;
      p00_r  <= ua_r[31:0]  * ub_r[31:0];
      p01_r  <= ua_r[31:0]  * ub_r[63:32];
      p10_r  <= ua_r[63:32] * ub_r[31:0];
      p11_r  <= ua_r[63:32] * ub_r[63:32];

      neg2_r <= neg1_r;
      sum_r  <= {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
              + {p11_r, 64'd0};
    end
  end

  assign p   = sum_r;
  assign neg = neg2_r;

endmodule

`default_nettype wire

### sv/tsh_div.sv
// Restoring divider, one quotient bit per stage, for quotients below 2^16.
`default_nettype none

module tsh_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n,
  input  logic [62:0] d,
  output logic [15:0] q
);
  import tsh_pkg::*;

  logic [63:0] r_r [DIV_STAGES];
  logic [62:0] d_r [DIV_STAGES];
  logic [15:0] q_r [DIV_STAGES];

  genvar j;
  generate
    for (j = 0; j < DIV_STAGES; j++) begin : g_bit
      logic [63:0] rin;
      logic [62:0] din;
      logic [15:0] qin;
      logic [78:0] dsh;
      logic        ge;
      if (j == 0) begin : g_first
        assign rin = n;
        assign din = d;
        assign qin = '0;
      end else begin : g_next
        assign rin = r_r[j-1];
        assign din = d_r[j-1];
        assign qin = q_r[j-1];
      end
      assign dsh = {16'd0, din} << (DIV_STAGES - 1 - j);
      assign ge  = {15'd0, rin} >= dsh;
      always_ff @(posedge clk) begin
        if (en) begin
          d_r[j] <= din;
          r_r[j] <= ge ? rin - dsh[63:0] : rin;
          q_r[j] <= {qin[14:0], ge};
        end
      end
    end
  endgenerate

  assign q = q_r[DIV_STAGES-1];

endmodule

`default_nettype wire

### sv/thermistor_steinhart_hart.sv
// Top level: divider voltage to Steinhart-Hart temperature, deep pipeline.
//
//  port group  dir  content (lowest bit first)
//  in_*        in   tdata: sense_millivolts[12:0], zero pad
//  out_*       out  tdata: temp_centi_c[15:0], status[17:16], zero pad
//  cfg_*       in   we, index (0 A, 1 B, 2 C, 3 divider, 4 reference), wdata
//
// One word per cycle while the output buffer is not full.
// Depth is set by the 32 log2 squaring stages, four 3-stage multipliers in series and
// the 16-stage quotient. Synchronous active-low reset clears valids and loads
// config defaults. A two-word output buffer takes results while the sink stalls;
// the pipeline holds when both are full.
`default_nettype none

module thermistor_steinhart_hart (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sense_millivolts[12:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // temp_centi_c[15:0], status[17:16]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);
  import tsh_pkg::*;

  localparam int S_LOG  = LOG_STAGES - 1;
  localparam int S_L2   = S_LOG + 1;
  localparam int S_LN   = S_L2 + MUL_STAGES + 1;
  localparam int S_SQ   = S_LN + MUL_STAGES + 1;
  localparam int S_ABL  = S_SQ + 1;
  localparam int S_LN3  = S_SQ + MUL_STAGES + 1;
  localparam int S_CL   = S_LN3 + MUL_STAGES + 1;
  localparam int S_D    = S_CL + 1;
  localparam int S_DIV0 = S_D + 1;
  localparam int NSTG   = S_DIV0 + DIV_STAGES + 1;
  localparam int LN_DLY = S_SQ - S_LN + 1;
  localparam int ABL_DLY = S_CL - S_ABL + 1;

  // configuration
  logic signed [47:0] coef_a_r, coef_b_r, coef_c_r;
  logic [19:0]        div_r;
  logic [12:0]        ref_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= 48'sd79241330900000;
      coef_b_r <= 48'sd16573706000000;
      coef_c_r <= 48'sd6341000000;
      div_r    <= 20'd10000;
      ref_r    <= 13'd3300;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COEF_A:  coef_a_r <= cfg_wdata;
        CFG_COEF_B:  coef_b_r <= cfg_wdata;
        CFG_COEF_C:  coef_c_r <= cfg_wdata;
        CFG_DIVIDER: div_r    <= cfg_wdata[19:0];
        CFG_REF:     ref_r    <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  logic go;
  logic [NSTG-1:0] vld_r;
  flag_t flag_r [NSTG];

  // stage 0 flags and log operands
  logic [12:0] v;
  flag_t       flag0;
  logic [19:0] xv, xr;

  assign v  = in_tdata[12:0];
  assign xv = {7'd0, v};
  assign xr = (v < ref_r) ? {7'd0, ref_r - v} : 20'd1;

  always_comb begin
    flag0 = '{st: ST_OK, sat: 1'b0};
    if (v >= ref_r)        flag0.st = ST_VHIGH;
    else if (v == 13'd0)   flag0.st = ST_VZERO;
    else if (div_r == '0)  flag0.st = ST_RANGE;
  end

  logic [36:0] yv, yd, yr;

  tsh_log2 u_log_v (.clk(clk), .en(go), .x(xv),    .y(yv));
  tsh_log2 u_log_d (.clk(clk), .en(go), .x(div_r), .y(yd));
  tsh_log2 u_log_r (.clk(clk), .en(go), .x(xr),    .y(yr));

  // arithmetic chain
  logic signed [63:0] l2_r, sq_r, bl_r, ln3_r, cl_r, d_r;
  logic signed [63:0] ln_d_r  [LN_DLY];
  logic signed [63:0] abl_d_r [ABL_DLY];
  logic [127:0] p_ln, p_sq, p_bl, p_ln3, p_cl;
  logic         n_ln, n_sq, n_bl, n_ln3, n_cl;

  tsh_mul u_mul_ln  (.clk(clk), .en(go), .a(l2_r), .b(LN2_Q62), .p(p_ln), .neg(n_ln));
  tsh_mul u_mul_sq  (.clk(clk), .en(go), .a(ln_d_r[0]), .b(ln_d_r[0]),
                     .p(p_sq), .neg(n_sq));
  tsh_mul u_mul_bl  (.clk(clk), .en(go), .a(64'(coef_b_r)), .b(ln_d_r[0]),
                     .p(p_bl), .neg(n_bl));
  tsh_mul u_mul_ln3 (.clk(clk), .en(go), .a(sq_r), .b(ln_d_r[LN_DLY-1]),
                     .p(p_ln3), .neg(n_ln3));
  tsh_mul u_mul_cl  (.clk(clk), .en(go), .a(64'(coef_c_r)), .b(ln3_r),
                     .p(p_cl), .neg(n_cl));

  // quotient set-up
  logic        dpos, big;
  logic [63:0] num;
  logic [63:0] n_r;
  logic [62:0] dd_r;
  logic [15:0] q;
  flag_t       flag_div;

  assign dpos = !d_r[63] && (d_r != '0);
  assign num  = KELVIN_SCALE + {1'b0, d_r[63:1]};
  assign big  = {15'd0, num} >= {d_r[62:0], 16'd0};

  // bad denominator or a quotient too large for the divider
  always_comb begin
    flag_div = flag_r[S_DIV0-1];
    if (flag_r[S_DIV0-1].st == ST_OK) begin
      priority if (!dpos) flag_div = '{st: ST_RANGE, sat: 1'b0};
      else if (big)       flag_div = '{st: ST_RANGE, sat: 1'b1};
    end
  end

  tsh_div u_div (.clk(clk), .en(go), .n(n_r), .d(dd_r), .q(q));

  always_ff @(posedge clk) begin
    if (go) begin
      l2_r      <= 64'({27'd0, yv} + {27'd0, yd} - {27'd0, yr});
      ln_d_r[0] <= mul_fin(p_ln, n_ln, 62);
      for (int i = 1; i < LN_DLY; i++) ln_d_r[i] <= ln_d_r[i-1];
      sq_r       <= mul_fin(p_sq, n_sq, 32);
      bl_r       <= mul_fin(p_bl, n_bl, 32);
      abl_d_r[0] <= sat_add(64'(coef_a_r), bl_r);
      for (int i = 1; i < ABL_DLY; i++) abl_d_r[i] <= abl_d_r[i-1];
      ln3_r <= mul_fin(p_ln3, n_ln3, 32);
      cl_r  <= mul_fin(p_cl, n_cl, 32);
      d_r   <= sat_add(abl_d_r[ABL_DLY-1], cl_r);
      n_r   <= num;
      dd_r  <= d_r[62:0];

      flag_r[0] <= flag0;
      for (int i = 1; i < NSTG; i++) begin
        flag_r[i] <= (i == S_DIV0) ? flag_div : flag_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (go) vld_r <= {vld_r[NSTG-2:0], in_tvalid};
  end

  // result from the last stage
  flag_t              fl;
  logic signed [16:0] t17;
  logic [17:0]        res;

  assign fl  = flag_r[NSTG-1];
  assign t17 = $signed({1'b0, q}) - KELVIN_CENTI;

  always_comb begin
    if (fl.st != ST_OK)
      res = {fl.st, fl.sat ? TEMP_MAX[15:0] : 16'd0};
    else if (t17 > TEMP_MAX)
      res = {ST_RANGE, TEMP_MAX[15:0]};
    else
      res = {ST_OK, t17[15:0]};
  end

  // two-word output buffer
  logic        out_valid_r, skid_valid_r;
  logic [17:0] out_data_r, skid_data_r;
  logic        pop, push;

  assign go   = !skid_valid_r;
  assign pop  = out_valid_r && out_tready;
  assign push = go && vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_tready  = go;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

`ifndef SYNTHESIS
  a_hold_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input held while output buffer not full");

  a_voltage_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[17:16] == ST_VHIGH || out_tdata[17:16] == ST_VZERO)
      |-> out_tdata[15:0] == 16'd0)
    else $error("voltage error word carries a temperature");

  a_temp_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[15:0]) <= $signed(TEMP_MAX[15:0]))
    else $error("temperature above saturation limit");

  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17:16] == ST_OK
      |-> $signed(out_tdata[15:0]) >= -$signed(KELVIN_CENTI[15:0]))
    else $error("temperature below absolute zero");
`endif

endmodule

`default_nettype wire
